### design/tanc_pkg.sv
// Shared widths, constants and pipeline transaction types for the triangle
// area, normal and centroid unit. No dependencies.
package tanc_pkg;

  localparam int CoordW   = 24;
  localparam int EdgeW    = CoordW + 1;
  localparam int ProdW    = 2 * EdgeW;
  localparam int MagW     = ProdW - 1;
  localparam int LoW      = 25;
  localparam int HiW      = MagW - LoW;
  localparam int SqW      = 2 * MagW;
  localparam int RadW     = SqW + 2;
  localparam int RootW    = RadW / 2;
  localparam int RemW     = RootW + 2;
  localparam int NormFrac = 30;
  localparam int QuoW     = NormFrac + 1;
  localparam int AreaW    = 52;
  localparam int NormW    = 32;
  localparam int CenSumW  = CoordW + 2;
  localparam int CenShift = 27;
  localparam logic [CenSumW-1:0] CenRecip = 26'd44739243;

  typedef struct packed {
    logic [2:0][MagW-1:0]   mag;
    logic [2:0]             neg;
    logic [2:0][CoordW-1:0] cen;
  } side_t;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    side_t            side;
  } sqrt_t;

  typedef struct packed {
    logic [RootW-1:0]       len;
    logic [2:0][RootW-1:0]  rem;
    logic [2:0]             nbit;
    logic [2:0][QuoW-1:0]   quo;
    logic [2:0]             neg;
    logic [2:0][CoordW-1:0] cen;
    logic [AreaW-1:0]       area;
  } div_t;

endpackage

### design/tanc_sqrt_cell.sv
// One restoring square-root cell: resolves one root bit per transaction.
// Depends on tanc_pkg.
module tanc_sqrt_cell import tanc_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t cell_i,
  output sqrt_t cell_o
);

  sqrt_t cell_d, cell_q;
  logic [RemW+1:0] rem_s, trial;
  logic            ge;

  always_comb begin
    rem_s  = {cell_i.rem, cell_i.rad[RadW-1 -: 2]};
    trial  = (RemW+2)'({cell_i.root, 2'b01});
    ge     = rem_s >= trial;
    cell_d = cell_i;
    cell_d.rad  = cell_i.rad << 2;
    cell_d.rem  = ge ? RemW'(rem_s - trial) : RemW'(rem_s);
    cell_d.root = {cell_i.root[RootW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### design/tanc_div_cell.sv
// One restoring division cell, three lanes sharing a divisor: one quotient
// bit per lane per transaction. Depends on tanc_pkg.
module tanc_div_cell import tanc_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t cell_i,
  output div_t cell_o
);

  div_t cell_d, cell_q;

  always_comb begin
    logic [RootW:0] rem_s;
    logic           ge;
    cell_d = cell_i;
    for (int l = 0; l < 3; l++) begin
      rem_s = {cell_i.rem[l], cell_i.nbit[l]};
      ge    = rem_s >= {1'b0, cell_i.len};
      cell_d.rem[l]  = ge ? RootW'(rem_s - {1'b0, cell_i.len}) : RootW'(rem_s);
      cell_d.quo[l]  = {cell_i.quo[l][QuoW-2:0], ge};
      cell_d.nbit[l] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### design/triangle_area_normal_centroid.sv
// Pipeline: 6 front stages (edges, products, cross, square parts,
// squares, sum), 50 square-root cells, divider set-up, 31 divider cells, output.
// Throughput one transaction per cycle; the whole pipeline holds while a
// result waits under stall. Reset (rst_ni low, asynchronous) clears all
// valid flags; data registers are not reset. Depends on tanc_pkg and cells.
module triangle_area_normal_centroid import tanc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic signed [CoordW-1:0] a_x_i,
  input  logic signed [CoordW-1:0] a_y_i,
  input  logic signed [CoordW-1:0] a_z_i,
  input  logic signed [CoordW-1:0] b_x_i,
  input  logic signed [CoordW-1:0] b_y_i,
  input  logic signed [CoordW-1:0] b_z_i,
  input  logic signed [CoordW-1:0] c_x_i,
  input  logic signed [CoordW-1:0] c_y_i,
  input  logic signed [CoordW-1:0] c_z_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic [AreaW-1:0]         area_o,
  output logic signed [NormW-1:0]  normal_x_o,
  output logic signed [NormW-1:0]  normal_y_o,
  output logic signed [NormW-1:0]  normal_z_o,
  output logic signed [CoordW-1:0] centroid_x_o,
  output logic signed [CoordW-1:0] centroid_y_o,
  output logic signed [CoordW-1:0] centroid_z_o,
  output logic                     degenerate_o
);

  localparam int NumStages = 6 + RootW + 1 + QuoW + 1;

  logic en;
  logic [NumStages-1:0] vld_q;

  logic signed [EdgeW-1:0]   e_q [3];
  logic signed [EdgeW-1:0]   f_q [3];
  logic signed [CenSumW-1:0] csum_q [3];
  logic signed [ProdW-1:0]   prod_q [6];
  logic [CenSumW-1:0]        cmag_q [3];
  logic [2:0]                cneg2_q;
  logic [MagW-1:0]           mag3_q [3];
  logic [2:0]                neg3_q, cneg3_q;
  logic [CoordW-1:0]         cq_q [3];
  logic [2*HiW-1:0]          hh_q [3];
  logic [HiW+LoW-1:0]        hl_q [3];
  logic [2*LoW-1:0]          ll_q [3];
  side_t                     side4_q, side5_q, side6_q;
  logic [SqW-1:0]            sq_q [3];
  logic [RadW-1:0]           rad_q;

  logic signed [ProdW-1:0]   cr [3];
  logic [ProdW-1:0]          cr_abs [3];
  logic [2*CenSumW-1:0]      cprod [3];

  sqrt_t sq_chain [RootW+1];
  div_t  dv_chain [QuoW+1];
  div_t  dv_d, dv_q;

  assign en      = !(vld_q[NumStages-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], valid_i};
    end
  end

  always_comb begin
    cr[0] = prod_q[0] - prod_q[1];
    cr[1] = prod_q[2] - prod_q[3];
    cr[2] = prod_q[4] - prod_q[5];
    for (int i = 0; i < 3; i++) begin
      cr_abs[i] = cr[i][ProdW-1] ? -cr[i] : cr[i];
      cprod[i]  = cmag_q[i] * CenRecip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q[0]    <= {b_x_i[CoordW-1], b_x_i} - {a_x_i[CoordW-1], a_x_i};
      e_q[1]    <= {b_y_i[CoordW-1], b_y_i} - {a_y_i[CoordW-1], a_y_i};
      e_q[2]    <= {b_z_i[CoordW-1], b_z_i} - {a_z_i[CoordW-1], a_z_i};
      f_q[0]    <= {c_x_i[CoordW-1], c_x_i} - {a_x_i[CoordW-1], a_x_i};
      f_q[1]    <= {c_y_i[CoordW-1], c_y_i} - {a_y_i[CoordW-1], a_y_i};
      f_q[2]    <= {c_z_i[CoordW-1], c_z_i} - {a_z_i[CoordW-1], a_z_i};
      csum_q[0] <= CenSumW'(a_x_i) + CenSumW'(b_x_i) + CenSumW'(c_x_i);
      csum_q[1] <= CenSumW'(a_y_i) + CenSumW'(b_y_i) + CenSumW'(c_y_i);
      csum_q[2] <= CenSumW'(a_z_i) + CenSumW'(b_z_i) + CenSumW'(c_z_i);

      prod_q[0] <= e_q[1] * f_q[2];
      prod_q[1] <= e_q[2] * f_q[1];
      prod_q[2] <= e_q[2] * f_q[0];
      prod_q[3] <= e_q[0] * f_q[2];
      prod_q[4] <= e_q[0] * f_q[1];
      prod_q[5] <= e_q[1] * f_q[0];
      for (int i = 0; i < 3; i++) begin
        cmag_q[i]  <= csum_q[i][CenSumW-1] ? CenSumW'(-csum_q[i]) : CenSumW'(csum_q[i]);
        cneg2_q[i] <= csum_q[i][CenSumW-1];

        mag3_q[i]  <= cr_abs[i][MagW-1:0];
        neg3_q[i]  <= cr[i][ProdW-1];
        cq_q[i]    <= cprod[i][CenShift +: CoordW];
        cneg3_q[i] <= cneg2_q[i];

        hh_q[i] <= mag3_q[i][MagW-1 -: HiW] * mag3_q[i][MagW-1 -: HiW];
        hl_q[i] <= mag3_q[i][MagW-1 -: HiW] * mag3_q[i][LoW-1:0];
        ll_q[i] <= mag3_q[i][LoW-1:0] * mag3_q[i][LoW-1:0];
        side4_q.mag[i] <= mag3_q[i];
        side4_q.neg[i] <= neg3_q[i];
        side4_q.cen[i] <= cneg3_q[i] ? -cq_q[i] : cq_q[i];

        sq_q[i] <= (SqW'(hh_q[i]) << (2 * LoW)) + (SqW'(hl_q[i]) << (LoW + 1))
                 + SqW'(ll_q[i]);
      end
      side5_q <= side4_q;
      rad_q   <= RadW'(sq_q[0]) + RadW'(sq_q[1]) + RadW'(sq_q[2]);
      side6_q <= side5_q;
    end
  end

  always_comb begin
    sq_chain[0].rad  = rad_q;
    sq_chain[0].rem  = '0;
    sq_chain[0].root = '0;
    sq_chain[0].side = side6_q;
  end

  for (genvar g = 0; g < RootW; g++) begin : g_sqrt
    tanc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (sq_chain[g]),
      .cell_o (sq_chain[g+1])
    );
  end

  always_comb begin
    dv_d.len  = sq_chain[RootW].root;
    dv_d.area = AreaW'(sq_chain[RootW].root >> 1);
    dv_d.neg  = sq_chain[RootW].side.neg;
    dv_d.cen  = sq_chain[RootW].side.cen;
    for (int l = 0; l < 3; l++) begin
      dv_d.rem[l]  = RootW'(sq_chain[RootW].side.mag[l] >> 1);
      dv_d.nbit[l] = sq_chain[RootW].side.mag[l][0];
      dv_d.quo[l]  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q <= dv_d;
    end
  end

  assign dv_chain[0] = dv_q;

  for (genvar g = 0; g < QuoW; g++) begin : g_div
    tanc_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (dv_chain[g]),
      .cell_o (dv_chain[g+1])
    );
  end

  logic [2:0][NormW-1:0] norm_d;
  logic                  degen_d;

  always_comb begin
    logic [NormW-1:0] q;
    degen_d = dv_chain[QuoW].len == '0;
    for (int l = 0; l < 3; l++) begin
      q = NormW'(dv_chain[QuoW].quo[l]);
      norm_d[l] = degen_d ? '0 : (dv_chain[QuoW].neg[l] ? -q : q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      area_o       <= dv_chain[QuoW].area;
      normal_x_o   <= norm_d[0];
      normal_y_o   <= norm_d[1];
      normal_z_o   <= norm_d[2];
      centroid_x_o <= dv_chain[QuoW].cen[0];
      centroid_y_o <= dv_chain[QuoW].cen[1];
      centroid_z_o <= dv_chain[QuoW].cen[2];
      degenerate_o <= degen_d;
    end
  end

`ifndef SYNTH
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> area_o == '0 && normal_x_o == '0 &&
      normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate result with non-zero area or normal");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |-> stall_o)
    else $error("pipeline advanced while result stalled");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (normal_x_o <= 32'sd1073741824) && (normal_x_o >= -32'sd1073741824) &&
      (normal_y_o <= 32'sd1073741824) && (normal_y_o >= -32'sd1073741824) &&
      (normal_z_o <= 32'sd1073741824) && (normal_z_o >= -32'sd1073741824))
    else $error("normal component beyond unit range");
`endif

endmodule
